// ===== src/reader_progress_rank_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the reader progress rank block
// Shared forms of the concurrent checks, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef READER_PROGRESS_RANK_DEFINES_SVH
`define READER_PROGRESS_RANK_DEFINES_SVH

// Condition cons must hold in the same cycle as ante.
`define RPR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition cons must hold in the cycle after ante.
`define RPR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Reader progress rank package
// Field widths, output select codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpr_pkg;

    localparam int FUNC_W  = 1;
    localparam int USER_W  = 12;
    localparam int PAGE_W  = 10;
    localparam int RATIO_W = 17;

    localparam logic [RATIO_W-1:0] ONE_Q16 = 17'd65536;

    // Source of the result loaded into the output register.
    localparam logic [1:0] OSEL_ZERO = 2'd0;
    localparam logic [1:0] OSEL_ONE  = 2'd1;
    localparam logic [1:0] OSEL_QUOT = 2'd2;

    typedef struct packed {
        logic       clr_step;
        logic       capture;
        logic       old_latch;
        logic       hist_rd_old;
        logic       hist_rd_page;
        logic       hist_wr_dec;
        logic       hist_wr_inc;
        logic       lp_wr;
        logic       total_inc;
        logic       walk_start;
        logic       walk_step;
        logic       div_start;
        logic       div_step;
        logic       out_load;
        logic [1:0] out_sel;
    } rpr_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic func;
        logic user_oob;
        logic page_bad;
        logic old_zero;
        logic total_le1;
        logic walk_done;
        logic div_done;
        logic out_free;
    } rpr_status_t;

endpackage

// ===== src/reader_progress_rank.sv =====
// ----------------------------------------------------------------------------
// Reader progress rank
// Per-user last page table with a page histogram and a rank ratio query.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                          | Direction | Items
//  ---------+----------------------------------+-----------+---------------------
//  in       | in_valid, in_ready, func/user/page | sink    | read or rank query
//  out      | out_valid, out_ready, rank_ratio | source    | one per rank query
//
//  A read looks up the progress table, reads and decrements the user's
//  old bucket, then reads and increments the new page's bucket. A user's
//  first read skips the old bucket, and a read with an out-of-range user
//  or a bad page is ignored. A rank query walks the buckets below the
//  user's page one after another through the single histogram read
//  port, then runs one restoring division step per cycle; a query for an
//  unknown user or a sole reader skips the walk and the division. After
//  reset a clearing pass zeroes both tables; no item is accepted during
//  it. A stalled result waits in the output register, and the next item
//  is taken meanwhile; a later query holds in its output state until
//  that register is free.
`timescale 1ns / 1ps

module reader_progress_rank #(
    parameter int USERS = 4096,
    parameter int PAGES = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rpr_pkg::FUNC_W-1:0]  func,
    input  logic [rpr_pkg::USER_W-1:0]  user,
    input  logic [rpr_pkg::PAGE_W-1:0]  page,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rpr_pkg::RATIO_W-1:0] rank_ratio
);

    // The controller only sequences; every table, counter and the divider
    // sit in the datapath and are driven by the command word each cycle.
    rpr_pkg::rpr_cmd_t    cmd;
    rpr_pkg::rpr_status_t status;

    rpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // A read moves the user out of the old bucket and into the new one, in
    // that order, so a reread of the same page leaves the histogram as it was.
    // A query sums the buckets below the user's page and divides the sum,
    // shifted up by sixteen bits, by the number of other readers.
    rpr_datapath #(
        .USERS (USERS),
        .PAGES (PAGES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .func       (func),
        .user       (user),
        .page       (page),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .rank_ratio (rank_ratio)
    );

endmodule

// ===== src/rpr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/rpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Reader progress rank controller
// Sequences the clearing pass, read updates and rank queries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "reader_progress_rank_defines.svh"

module rpr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rpr_pkg::rpr_status_t status,
    output rpr_pkg::rpr_cmd_t    cmd
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_LP_RD    = 4'd2;
    localparam logic [3:0] S_LP_WAIT  = 4'd3;
    localparam logic [3:0] S_DISPATCH = 4'd4;
    localparam logic [3:0] S_OLD_RD   = 4'd5;
    localparam logic [3:0] S_OLD_WR   = 4'd6;
    localparam logic [3:0] S_NEW_RD   = 4'd7;
    localparam logic [3:0] S_NEW_WR   = 4'd8;
    localparam logic [3:0] S_WALK     = 4'd9;
    localparam logic [3:0] S_DIV      = 4'd10;
    localparam logic [3:0] S_OUT      = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] osel_reg;
    logic [1:0] osel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            osel_reg  <= rpr_pkg::OSEL_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            osel_reg  <= osel_next;
        end
    end

    always_comb
    begin
        cmd         = '0;
        cmd.out_sel = osel_reg;
        state_next  = state_reg;
        osel_next   = osel_reg;
        in_ready    = (state_reg == S_IDLE);
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LP_RD;
                end
            end
            S_LP_RD:
            begin
                if (status.user_oob)
                begin
                    if (status.func)
                    begin
                        osel_next  = rpr_pkg::OSEL_ZERO;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (!status.func && status.page_bad)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_LP_WAIT;
                end
            end
            S_LP_WAIT:
            begin
                cmd.old_latch = 1'b1;
                state_next    = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                if (status.func)
                begin
                    if (status.old_zero)
                    begin
                        osel_next  = rpr_pkg::OSEL_ZERO;
                        state_next = S_OUT;
                    end
                    else if (status.total_le1)
                    begin
                        osel_next  = rpr_pkg::OSEL_ONE;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.walk_start = 1'b1;
                        state_next     = S_WALK;
                    end
                end
                else if (status.old_zero)
                begin
                    state_next = S_NEW_RD;
                end
                else
                begin
                    state_next = S_OLD_RD;
                end
            end
            S_OLD_RD:
            begin
                cmd.hist_rd_old = 1'b1;
                state_next      = S_OLD_WR;
            end
            S_OLD_WR:
            begin
                cmd.hist_wr_dec = 1'b1;
                state_next      = S_NEW_RD;
            end
            S_NEW_RD:
            begin
                cmd.hist_rd_page = 1'b1;
                state_next       = S_NEW_WR;
            end
            S_NEW_WR:
            begin
                cmd.hist_wr_inc = 1'b1;
                cmd.lp_wr       = 1'b1;
                cmd.total_inc   = status.old_zero;
                state_next      = S_IDLE;
            end
            S_WALK:
            begin
                if (status.walk_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    osel_next  = rpr_pkg::OSEL_QUOT;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `RPR_ASSERT_IMP(a_load_slot_free, cmd.out_load, status.out_free, "result loaded over a waiting one")
    `RPR_ASSERT_NXT(a_accept_to_lookup, in_valid && in_ready, state_reg == S_LP_RD, "item not looked up")
    `RPR_ASSERT_IMP(a_dec_known_user, cmd.hist_wr_dec, !status.old_zero, "bucket decremented for a new reader")

endmodule

// ===== src/rpr_datapath.sv =====
// ----------------------------------------------------------------------------
// Reader progress rank datapath
// Progress table, page histogram, reader count, walk accumulator and divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "reader_progress_rank_defines.svh"

module rpr_datapath #(
    parameter int USERS = 4096,
    parameter int PAGES = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [rpr_pkg::FUNC_W-1:0]        func,
    input  logic [rpr_pkg::USER_W-1:0]        user,
    input  logic [rpr_pkg::PAGE_W-1:0]        page,
    input  rpr_pkg::rpr_cmd_t                 cmd,
    output rpr_pkg::rpr_status_t              status,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rpr_pkg::RATIO_W-1:0]       rank_ratio
);

    localparam int UW    = $clog2(USERS);
    localparam int PW    = $clog2(PAGES);
    localparam int CW    = $clog2(USERS + 1);
    localparam int DEPTH = (USERS > PAGES) ? USERS : PAGES;
    localparam int KW    = $clog2(DEPTH);
    localparam int DN    = CW + 16;
    localparam int DCW   = $clog2(DN + 1);

    // Captured item.
    logic          func_reg;
    logic [UW-1:0] user_idx_reg;
    logic          user_oob_reg;
    logic [PW-1:0] page_idx_reg;
    logic          page_bad_reg;

    logic [KW-1:0] clr_reg;
    logic [PW-1:0] old_reg;
    logic [CW-1:0] total_reg;

    logic [PW-1:0] p_reg;
    logic          pend_reg;
    logic [CW-1:0] acc_reg;

    logic [DCW-1:0] div_cnt_reg;
    logic [DN-1:0]  dvd_reg;
    logic [CW-1:0]  rem_reg;
    logic [CW-1:0]  dsr_reg;

    logic                       out_valid_reg;
    logic [rpr_pkg::RATIO_W-1:0] ratio_reg;

    logic          lp_we;
    logic [UW-1:0] lp_waddr;
    logic [PW-1:0] lp_wdata;
    logic [PW-1:0] lp_rdata;

    logic          hist_we;
    logic [PW-1:0] hist_waddr;
    logic [CW-1:0] hist_wdata;
    logic [PW-1:0] hist_raddr;
    logic [CW-1:0] hist_rdata;

    logic          clr_in_users;
    logic          clr_in_pages;
    logic          walk_more;
    logic [CW:0]   rem_shift;
    logic          rem_ge;
    logic [rpr_pkg::RATIO_W-1:0] quot_clamped;
    logic [rpr_pkg::RATIO_W-1:0] ratio_sel;

    assign clr_in_users = (32'(clr_reg) < USERS);
    assign clr_in_pages = (32'(clr_reg) < PAGES);
    assign walk_more    = (p_reg < old_reg);

    // Progress table.
    assign lp_we    = (cmd.clr_step && clr_in_users) || cmd.lp_wr;
    assign lp_waddr = cmd.clr_step ? UW'(clr_reg) : user_idx_reg;
    assign lp_wdata = cmd.clr_step ? '0 : page_idx_reg;

    rpr_ram #(
        .WIDTH (PW),
        .DEPTH (USERS)
    ) u_last_page (
        .clk   (clk),
        .we    (lp_we),
        .waddr (lp_waddr),
        .wdata (lp_wdata),
        .raddr (user_idx_reg),
        .rdata (lp_rdata)
    );

    // Page histogram.
    always_comb
    begin
        if (cmd.hist_rd_old)
        begin
            hist_raddr = old_reg;
        end
        else if (cmd.hist_rd_page)
        begin
            hist_raddr = page_idx_reg;
        end
        else
        begin
            hist_raddr = p_reg;
        end

        hist_we = (cmd.clr_step && clr_in_pages) || cmd.hist_wr_dec || cmd.hist_wr_inc;
        if (cmd.clr_step)
        begin
            hist_waddr = PW'(clr_reg);
            hist_wdata = '0;
        end
        else if (cmd.hist_wr_dec)
        begin
            hist_waddr = old_reg;
            hist_wdata = hist_rdata - CW'(1);
        end
        else
        begin
            hist_waddr = page_idx_reg;
            hist_wdata = hist_rdata + CW'(1);
        end
    end

    rpr_ram #(
        .WIDTH (CW),
        .DEPTH (PAGES)
    ) u_readers_at_page (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // One restoring division step.
    assign rem_shift = {rem_reg, dvd_reg[DN-1]};
    assign rem_ge    = (rem_shift >= {1'b0, dsr_reg});

    assign quot_clamped = (dvd_reg > DN'(rpr_pkg::ONE_Q16)) ? rpr_pkg::ONE_Q16
                                                           : dvd_reg[rpr_pkg::RATIO_W-1:0];

    always_comb
    begin
        case (cmd.out_sel)
            rpr_pkg::OSEL_ONE:  ratio_sel = rpr_pkg::ONE_Q16;
            rpr_pkg::OSEL_QUOT: ratio_sel = quot_clamped;
            default:            ratio_sel = '0;
        endcase
    end

    // Item fields and working registers; no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg     <= func[0];
            user_idx_reg <= UW'(user);
            user_oob_reg <= (32'(user) >= USERS);
            page_idx_reg <= PW'(page);
            page_bad_reg <= (page == '0) || (32'(page) >= PAGES);
        end
        if (cmd.old_latch)
        begin
            old_reg <= lp_rdata;
        end
        if (cmd.walk_start)
        begin
            p_reg   <= PW'(1);
            acc_reg <= '0;
        end
        else
        begin
            if (cmd.walk_step && walk_more)
            begin
                p_reg <= p_reg + PW'(1);
            end
            if (pend_reg)
            begin
                acc_reg <= acc_reg + hist_rdata;
            end
        end
        if (cmd.div_start)
        begin
            dvd_reg <= {acc_reg, 16'd0};
            rem_reg <= '0;
            dsr_reg <= total_reg - CW'(1);
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[DN-2:0], rem_ge};
            rem_reg <= rem_ge ? CW'(rem_shift - {1'b0, dsr_reg}) : rem_shift[CW-1:0];
        end
        if (cmd.out_load)
        begin
            ratio_reg <= ratio_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            total_reg     <= '0;
            pend_reg      <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + KW'(1);
            end
            if (cmd.total_inc)
            begin
                total_reg <= total_reg + CW'(1);
            end
            pend_reg <= cmd.walk_step && walk_more;
            if (cmd.div_start)
            begin
                div_cnt_reg <= DCW'(DN);
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg - DCW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clear_done = (clr_reg == KW'(DEPTH - 1));
    assign status.func       = func_reg;
    assign status.user_oob   = user_oob_reg;
    assign status.page_bad   = page_bad_reg;
    assign status.old_zero   = (old_reg == '0);
    assign status.total_le1  = (total_reg <= CW'(1));
    assign status.walk_done  = !walk_more && !pend_reg;
    assign status.div_done   = (div_cnt_reg == '0);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign rank_ratio = ratio_reg;

    `RPR_ASSERT_NXT(a_total_monotonic, 1'b1, total_reg >= $past(total_reg), "reader count fell")

endmodule
